>>> rtl/core/tsau_pkg.sv
// Package for the tile scroll address unit: event codes, address constants
// and the coarse X and Y increment functions. No dependencies.
`timescale 1ns / 1ps

package tsau_pkg;

	// Event codes carried on the func field.
	localparam logic [3:0] FUNC_CTRL_WR   = 4'd0;
	localparam logic [3:0] FUNC_SCROLL_WR = 4'd1;
	localparam logic [3:0] FUNC_ADDR_WR   = 4'd2;
	localparam logic [3:0] FUNC_DATA      = 4'd3;
	localparam logic [3:0] FUNC_STATUS    = 4'd4;
	localparam logic [3:0] FUNC_INC_X     = 4'd5;
	localparam logic [3:0] FUNC_INC_Y     = 4'd6;
	localparam logic [3:0] FUNC_COPY_X    = 4'd7;
	localparam logic [3:0] FUNC_COPY_Y    = 4'd8;

	// Field widths.
	localparam int unsigned VADDR_W = 15;
	localparam int unsigned BUS_W   = 14;

	typedef logic [VADDR_W-1:0] vaddr_t;
	typedef logic [BUS_W-1:0]   bus_addr_t;

	// Fetch address bases and coarse Y wrap points.
	localparam bus_addr_t  NT_BASE     = 14'h2000;
	localparam bus_addr_t  AT_BASE     = 14'h23C0;
	localparam logic [4:0] CY_LAST_ROW = 5'd29;
	localparam logic [4:0] CY_MAX      = 5'd31;

	// Transfer masks for the horizontal and vertical copies from t to v.
	localparam vaddr_t COPY_X_MASK = 15'h041F;
	localparam vaddr_t COPY_Y_MASK = 15'h7BE0;

	// Coarse X increment: wraps from 31 to 0 and flips nametable X.
	function automatic vaddr_t inc_coarse_x(input vaddr_t v);
		vaddr_t r;
		r = v;
		if (v[4:0] == CY_MAX) begin
			r[4:0] = 5'd0;
			r[10]  = ~v[10];
		end else begin
			r[4:0] = v[4:0] + 5'd1;
		end
		return r;
	endfunction

	// Y increment: fine Y counts first, then coarse Y with its two wrap points.
	function automatic vaddr_t inc_y(input vaddr_t v);
		vaddr_t r;
		r = v;
		if (v[14:12] != 3'd7) begin
			r[14:12] = v[14:12] + 3'd1;
		end else begin
			r[14:12] = 3'd0;
			if (v[9:5] == CY_LAST_ROW) begin
				r[9:5] = 5'd0;
				r[11]  = ~v[11];
			end else if (v[9:5] == CY_MAX) begin
				r[9:5] = 5'd0;
			end else begin
				r[9:5] = v[9:5] + 5'd1;
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/tile_scroll_address_unit_top.sv
// A taken request is held in the input register, and its result is loaded into the
// result register once that register is empty or its result is taken by the receiver.
// Throughput: one request per cycle unless the receiver holds back results; the input
// register and the result register form a two-stage pipe whose state update is done
// in a single pass of logic. Reset (arst_n low, asynchronous) clears v, t, fine X, the
// write toggle, the increment mode and both valid flags. Depends on tsau_pkg.
`timescale 1ns / 1ps

module tile_scroll_address_unit_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [3:0]          func,
	input  logic [7:0]          data,
	input  logic                render_on,
	output logic                res_valid,
	input  logic                res_ready,
	output tsau_pkg::bus_addr_t access_addr,
	output tsau_pkg::vaddr_t    v_addr,
	output tsau_pkg::vaddr_t    t_addr,
	output logic [2:0]          fine_scroll_x,
	output logic                toggle_out,
	output tsau_pkg::bus_addr_t nt_fetch_addr,
	output tsau_pkg::bus_addr_t at_fetch_addr,
	output logic [2:0]          at_shift
);
	import tsau_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [3:0] func_s1;
	logic [7:0] data_s1;
	logic       render_s1;

	// Architectural state.
	vaddr_t     cur_addr_q;
	vaddr_t     temp_addr_q;
	logic [2:0] fine_x_q;
	logic       toggle_q;
	logic       row_step_q;

	// Next-state values.
	vaddr_t     cur_addr_d;
	vaddr_t     temp_addr_d;
	logic [2:0] fine_x_d;
	logic       toggle_d;
	logic       row_step_d;
	bus_addr_t  access_d;

	// Result register.
	logic       res_valid_q;
	bus_addr_t  access_q;
	vaddr_t     v_q;
	vaddr_t     t_q;
	logic [2:0] fine_x_out_q;
	logic       toggle_out_q;
	bus_addr_t  nt_q;
	bus_addr_t  at_q;
	logic [2:0] at_shift_q;

	logic advance;
	logic fire_s1;

	// The result register frees up when empty or when its result is taken.
	assign advance   = !res_valid_q || res_ready;
	assign fire_s1   = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;

	// Event decode and state update for the request in the input register.
	always_comb begin
		cur_addr_d  = cur_addr_q;
		temp_addr_d = temp_addr_q;
		fine_x_d    = fine_x_q;
		toggle_d    = toggle_q;
		row_step_d  = row_step_q;
		access_d    = '0;
		case (func_s1)
			FUNC_CTRL_WR: begin
				temp_addr_d[11:10] = data_s1[1:0];
				row_step_d         = data_s1[2];
			end
			FUNC_SCROLL_WR: begin
				if (!toggle_q) begin
					temp_addr_d[4:0] = data_s1[7:3];
					fine_x_d         = data_s1[2:0];
					toggle_d         = 1'b1;
				end else begin
					temp_addr_d[9:5]   = data_s1[7:3];
					temp_addr_d[14:12] = data_s1[2:0];
					toggle_d           = 1'b0;
				end
			end
			FUNC_ADDR_WR: begin
				if (!toggle_q) begin
					temp_addr_d = {1'b0, data_s1[5:0], 8'd0};
					toggle_d    = 1'b1;
				end else begin
					temp_addr_d = {temp_addr_q[14:8], data_s1};
					cur_addr_d  = {temp_addr_q[14:8], data_s1};
					toggle_d    = 1'b0;
				end
			end
			FUNC_DATA: begin
				access_d   = cur_addr_q[BUS_W-1:0];
				cur_addr_d = cur_addr_q + (row_step_q ? 15'd32 : 15'd1);
			end
			FUNC_STATUS: begin
				toggle_d = 1'b0;
			end
			FUNC_INC_X: begin
				if (render_s1) begin
					cur_addr_d = inc_coarse_x(cur_addr_q);
				end
			end
			FUNC_INC_Y: begin
				if (render_s1) begin
					cur_addr_d = inc_y(cur_addr_q);
				end
			end
			FUNC_COPY_X: begin
				if (render_s1) begin
					cur_addr_d = (cur_addr_q & ~COPY_X_MASK) | (temp_addr_q & COPY_X_MASK);
				end
			end
			FUNC_COPY_Y: begin
				if (render_s1) begin
					cur_addr_d = (cur_addr_q & ~COPY_Y_MASK) | (temp_addr_q & COPY_Y_MASK);
				end
			end
			default: begin
			end
		endcase
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			func_s1   <= func;
			data_s1   <= data;
			render_s1 <= render_on;
		end
	end

	// State registers update once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q  <= '0;
			temp_addr_q <= '0;
			fine_x_q    <= '0;
			toggle_q    <= 1'b0;
			row_step_q  <= 1'b0;
		end else if (fire_s1) begin
			cur_addr_q  <= cur_addr_d;
			temp_addr_q <= temp_addr_d;
			fine_x_q    <= fine_x_d;
			toggle_q    <= toggle_d;
			row_step_q  <= row_step_d;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	// Result register payload, including the fetch addresses taken from the new v.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			access_q     <= access_d;
			v_q          <= cur_addr_d;
			t_q          <= temp_addr_d;
			fine_x_out_q <= fine_x_d;
			toggle_out_q <= toggle_d;
			nt_q         <= NT_BASE | {2'b00, cur_addr_d[11:0]};
			at_q         <= AT_BASE | {2'b00, cur_addr_d[11:10], 4'b0000,
				cur_addr_d[9:7], cur_addr_d[4:2]};
			at_shift_q   <= {cur_addr_d[6], cur_addr_d[1], 1'b0};
		end
	end

	assign res_valid     = res_valid_q;
	assign access_addr   = access_q;
	assign v_addr        = v_q;
	assign t_addr        = t_q;
	assign fine_scroll_x = fine_x_out_q;
	assign toggle_out    = toggle_out_q;
	assign nt_fetch_addr = nt_q;
	assign at_fetch_addr = at_q;
	assign at_shift      = at_shift_q;

	// A new result only appears after a request sat in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a request in the input register");

	// Scroll and address writes always flip the shared write toggle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && (func_s1 == FUNC_SCROLL_WR || func_s1 == FUNC_ADDR_WR))
		|=> (toggle_q != $past(toggle_q)))
		else $error("write toggle did not flip on a paired write");

	// A status read leaves v untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && func_s1 == FUNC_STATUS) |=> (cur_addr_q == $past(cur_addr_q)))
		else $error("status read changed the current address");

	// The state only moves when a request is processed.
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> ($stable(cur_addr_q) && $stable(temp_addr_q) && $stable(toggle_q)))
		else $error("state changed without a processed request");

endmodule

>>> verif/tile_scroll_address_unit_top_tb.sv
// Self-checking testbench for tile_scroll_address_unit_top: directed and random scroll,
// address and render events, checked against a behavioral predictor of v, t and fine X.
// Depends on tsau_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tile_scroll_address_unit_top_tb;
	import tsau_pkg::*;

	// Func codes that the block ignores.
	localparam logic [3:0] FUNC_UNUSED_LO = 4'd9;
	localparam logic [3:0] FUNC_UNUSED_HI = 4'd15;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int DRAIN_CYCLES   = 6;
	localparam int RANDOM_PER_RUN = 320;
	localparam int MAX_REPORTS    = 40;

	typedef struct packed {
		bus_addr_t  access;
		vaddr_t     v;
		vaddr_t     t;
		logic [2:0] fine_x;
		logic       toggle;
		bus_addr_t  nt;
		bus_addr_t  at;
		logic [2:0] shift;
	} scroll_result_t;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	logic [3:0] func;
	logic [7:0] data;
	logic       render_on;
	logic       res_valid;
	logic       res_ready;
	bus_addr_t  access_addr;
	vaddr_t     v_addr;
	vaddr_t     t_addr;
	logic [2:0] fine_scroll_x;
	logic       toggle_out;
	bus_addr_t  nt_fetch_addr;
	bus_addr_t  at_fetch_addr;
	logic [2:0] at_shift;

	// Predicted architectural state.
	vaddr_t     v_pred;
	vaddr_t     t_pred;
	logic [2:0] fine_x_pred;
	logic       toggle_pred;
	logic       row_step_pred;

	scroll_result_t expected_results[$];
	int mismatch_count;
	int sender_idle_pct;
	int rx_stall_pct;
	int hold_off_left;
	int cycle_count;

	tile_scroll_address_unit_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.func         (func),
		.data         (data),
		.render_on    (render_on),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.access_addr  (access_addr),
		.v_addr       (v_addr),
		.t_addr       (t_addr),
		.fine_scroll_x(fine_scroll_x),
		.toggle_out   (toggle_out),
		.nt_fetch_addr(nt_fetch_addr),
		.at_fetch_addr(at_fetch_addr),
		.at_shift     (at_shift)
	);

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one event to the predicted state and form the result it reports.
	task automatic predict_scroll_event(input logic [3:0] f, input logic [7:0] d,
		input logic r, output scroll_result_t res);
		res.access = '0;
		case (f)
		FUNC_CTRL_WR: begin
			t_pred[11:10] = d[1:0];
			row_step_pred = d[2];
		end
		FUNC_SCROLL_WR: begin
			if (!toggle_pred) begin
				t_pred[4:0] = d[7:3];
				fine_x_pred = d[2:0];
				toggle_pred = 1'b1;
			end else begin
				t_pred[9:5]   = d[7:3];
				t_pred[14:12] = d[2:0];
				toggle_pred   = 1'b0;
			end
		end
		FUNC_ADDR_WR: begin
			// The first write clears the low byte and the top bit of t.
			if (!toggle_pred) begin
				t_pred      = {1'b0, d[5:0], 8'h00};
				toggle_pred = 1'b1;
			end else begin
				t_pred[7:0] = d;
				v_pred      = t_pred;
				toggle_pred = 1'b0;
			end
		end
		FUNC_DATA: begin
			res.access = v_pred[13:0];
			v_pred     = v_pred + (row_step_pred ? 15'd32 : 15'd1);
		end
		FUNC_STATUS: begin
			toggle_pred = 1'b0;
		end
		FUNC_INC_X: begin
			if (r) begin
				if (&v_pred[4:0]) begin
					v_pred[4:0] = 5'd0;
					v_pred[10]  = ~v_pred[10];
				end else begin
					v_pred[4:0] = v_pred[4:0] + 5'd1;
				end
			end
		end
		FUNC_INC_Y: begin
			if (r) begin
				if (v_pred[14:12] != 3'd7) begin
					v_pred[14:12] = v_pred[14:12] + 3'd1;
				end else begin
					v_pred[14:12] = 3'd0;
					// Row 29 is the last visible row; 31 wraps without a flip and
					// 30 counts up into 31.
					case (v_pred[9:5])
					5'd29: begin
						v_pred[9:5] = 5'd0;
						v_pred[11]  = ~v_pred[11];
					end
					5'd31: begin
						v_pred[9:5] = 5'd0;
					end
					default: begin
						v_pred[9:5] = v_pred[9:5] + 5'd1;
					end
					endcase
				end
			end
		end
		FUNC_COPY_X: begin
			if (r) begin
				v_pred = (v_pred & ~COPY_X_MASK) | (t_pred & COPY_X_MASK);
			end
		end
		FUNC_COPY_Y: begin
			if (r) begin
				v_pred = (v_pred & ~COPY_Y_MASK) | (t_pred & COPY_Y_MASK);
			end
		end
		default: begin
		end
		endcase
		res.v      = v_pred;
		res.t      = t_pred;
		res.fine_x = fine_x_pred;
		res.toggle = toggle_pred;
		res.nt     = NT_BASE | {2'b00, v_pred[11:0]};
		res.at     = AT_BASE | {2'b00, v_pred[11:10], 4'b0000, v_pred[9:7], v_pred[4:2]};
		res.shift  = {v_pred[6], v_pred[1], 1'b0};
	endtask

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
		end
	endtask

	// Offer one request, with random idle gaps before it, and record its result.
	task automatic send_request(input logic [3:0] f, input logic [7:0] d, input logic r);
		scroll_result_t res;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid = 1'b0;
			func      = 4'($urandom);
			data      = 8'($urandom);
			render_on = 1'($urandom);
			@(negedge clk);
		end
		req_valid = 1'b1;
		func      = f;
		data      = d;
		render_on = r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_scroll_event(f, d, r, res);
		expected_results.push_back(res);
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected result has come out.
	task automatic wait_for_results();
		req_valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Pick one event, weighted toward the ones that move v and t.
	task automatic pick_random_event(output logic [3:0] f, output logic [7:0] d,
		output logic r);
		int pick;
		pick = $urandom_range(99);
		d    = 8'($urandom);
		r    = ($urandom_range(99) < 85);
		if (pick < 6) f = FUNC_CTRL_WR;
		else if (pick < 18) f = FUNC_SCROLL_WR;
		else if (pick < 30) f = FUNC_ADDR_WR;
		else if (pick < 42) f = FUNC_DATA;
		else if (pick < 48) f = FUNC_STATUS;
		else if (pick < 66) f = FUNC_INC_X;
		else if (pick < 78) f = FUNC_INC_Y;
		else if (pick < 88) f = FUNC_COPY_X;
		else if (pick < 95) f = FUNC_COPY_Y;
		else f = 4'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
	endtask

	// Random traffic: register write pairs, scanline-like render runs and single events.
	task automatic run_random_events(input int count);
		int sent;
		int kind;
		int k;
		logic [3:0] f;
		logic [7:0] d;
		logic r;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				// A status read resets the toggle, then a full write pair.
				send_request(FUNC_STATUS, 8'($urandom), 1'($urandom));
				f = ($urandom_range(1) != 0) ? FUNC_SCROLL_WR : FUNC_ADDR_WR;
				send_request(f, 8'($urandom), 1'($urandom));
				send_request(f, 8'($urandom), 1'($urandom));
				sent += 3;
			end else if (kind < 60) begin
				// One scanline: reload X, step across tiles, then step down.
				send_request(FUNC_COPY_X, 8'($urandom), 1'b1);
				k = $urandom_range(8, 1);
				repeat (k) send_request(FUNC_INC_X, 8'($urandom), 1'b1);
				send_request(FUNC_INC_Y, 8'($urandom), 1'b1);
				if ($urandom_range(9) == 0) send_request(FUNC_COPY_Y, 8'($urandom), 1'b1);
				sent += k + 2;
			end else begin
				pick_random_event(f, d, r);
				send_request(f, d, r);
				sent++;
			end
			if ($urandom_range(99) == 0) wait_for_results();
		end
		wait_for_results();
	endtask

	// Extremes of every field, every event and the wrap cases of v and t.
	task automatic test_directed();
		sender_idle_pct = 0;
		rx_stall_pct    = 0;
		send_request(FUNC_CTRL_WR, 8'hFF, 1'b0);
		send_request(FUNC_SCROLL_WR, 8'hFF, 1'b0);
		send_request(FUNC_SCROLL_WR, 8'hFF, 1'b0);
		// Both copies together load all of t into v.
		send_request(FUNC_COPY_X, 8'h00, 1'b1);
		send_request(FUNC_COPY_Y, 8'h00, 1'b1);
		// Data access stepping by 32 wraps v past the top.
		send_request(FUNC_DATA, 8'h00, 1'b0);
		send_request(FUNC_INC_X, 8'h00, 1'b1);
		send_request(FUNC_COPY_Y, 8'h00, 1'b1);
		// Coarse Y at 31 wraps without a nametable flip.
		send_request(FUNC_INC_Y, 8'h00, 1'b1);
		// With rendering off the render events change nothing.
		send_request(FUNC_INC_X, 8'hFF, 1'b0);
		send_request(FUNC_INC_Y, 8'hFF, 1'b0);
		send_request(FUNC_COPY_X, 8'hFF, 1'b0);
		send_request(FUNC_COPY_Y, 8'hFF, 1'b0);
		// Coarse Y at 29 with fine Y 7 wraps and flips nametable Y.
		send_request(FUNC_SCROLL_WR, 8'h00, 1'b1);
		send_request(FUNC_SCROLL_WR, 8'hEF, 1'b1);
		send_request(FUNC_COPY_Y, 8'h00, 1'b1);
		send_request(FUNC_INC_Y, 8'h00, 1'b1);
		send_request(FUNC_CTRL_WR, 8'h00, 1'b1);
		send_request(FUNC_ADDR_WR, 8'hFF, 1'b0);
		send_request(FUNC_ADDR_WR, 8'hFF, 1'b0);
		send_request(FUNC_DATA, 8'hFF, 1'b1);
		// A status read in the middle of a pair restarts it.
		send_request(FUNC_SCROLL_WR, 8'h55, 1'b0);
		send_request(FUNC_STATUS, 8'hAA, 1'b1);
		send_request(FUNC_ADDR_WR, 8'h00, 1'b0);
		send_request(FUNC_UNUSED_LO, 8'hFF, 1'b1);
		send_request(FUNC_UNUSED_HI, 8'hFF, 1'b1);
		wait_for_results();
	endtask

	task automatic test_random_no_idle();
		sender_idle_pct = 0;
		rx_stall_pct    = 0;
		run_random_events(RANDOM_PER_RUN);
	endtask

	task automatic test_random_sender_idle();
		sender_idle_pct = 60;
		rx_stall_pct    = 0;
		run_random_events(RANDOM_PER_RUN);
	endtask

	task automatic test_random_receiver_stall();
		sender_idle_pct = 0;
		rx_stall_pct    = 60;
		run_random_events(RANDOM_PER_RUN);
	endtask

	task automatic test_random_both_idle();
		sender_idle_pct = 28;
		rx_stall_pct    = 28;
		run_random_events(RANDOM_PER_RUN);
	endtask

	// The receiver holds off long enough for the pipe to fill and stall its input.
	task automatic test_backpressure_fill();
		logic [3:0] f;
		logic [7:0] d;
		logic r;
		sender_idle_pct = 0;
		rx_stall_pct    = 0;
		req_valid = 1'b0;
		@(posedge clk);
		hold_off_left = 120;
		@(negedge clk);
		repeat (60) begin
			pick_random_event(f, d, r);
			send_request(f, d, r);
		end
		wait_for_results();
	endtask

	// Receiver ready, with random stalls and the long hold-off.
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			res_ready = 1'b0;
			hold_off_left--;
		end else begin
			res_ready = ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Compare each delivered result with the oldest expectation.
	always @(posedge clk) begin
		scroll_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, v_addr", v_addr, 0);
			end else begin
				want = expected_results.pop_front();
				if (access_addr !== want.access)
					report_mismatch("access_addr", access_addr, want.access);
				if (v_addr !== want.v) report_mismatch("v_addr", v_addr, want.v);
				if (t_addr !== want.t) report_mismatch("t_addr", t_addr, want.t);
				if (fine_scroll_x !== want.fine_x)
					report_mismatch("fine_scroll_x", fine_scroll_x, want.fine_x);
				if (toggle_out !== want.toggle)
					report_mismatch("toggle_out", toggle_out, want.toggle);
				if (nt_fetch_addr !== want.nt)
					report_mismatch("nt_fetch_addr", nt_fetch_addr, want.nt);
				if (at_fetch_addr !== want.at)
					report_mismatch("at_fetch_addr", at_fetch_addr, want.at);
				if (at_shift !== want.shift) report_mismatch("at_shift", at_shift, want.shift);
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tile_scroll_address_unit_top verification failed");
		$finish;
	end

	// Reset, then run each test in turn.
	initial begin
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		func            = FUNC_CTRL_WR;
		data            = 8'h00;
		render_on       = 1'b0;
		res_ready       = 1'b0;
		hold_off_left   = 0;
		sender_idle_pct = 0;
		rx_stall_pct    = 0;
		mismatch_count  = 0;
		v_pred          = '0;
		t_pred          = '0;
		fine_x_pred     = '0;
		toggle_pred     = 1'b0;
		row_step_pred   = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_no_idle();
		test_random_sender_idle();
		test_backpressure_fill();
		test_random_receiver_stall();
		test_random_both_idle();
		wait_for_results();

		if (mismatch_count == 0) begin
			$display("tile_scroll_address_unit_top verification clean");
		end else begin
			$display("tile_scroll_address_unit_top verification failed");
		end
		$finish;
	end

endmodule
